@@ rtl/core/isotp_pkg.sv @@
// Package: shared types and constants of the ISO-TP segmented transmitter.
`default_nettype none
package isotp_pkg;
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_ABORT  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] PCI_FF = 8'h10;
  localparam logic [7:0] PCI_CF = 8'h20;
  localparam logic [7:0] PCI_FC = 8'h30;
  localparam logic [7:0] PCI_TYPE_MASK = 8'hF0;
  localparam logic [7:0] GAP_MS_MAX = 8'h7F;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] service;
    logic [31:0] address;
    logic [15:0] length;
    logic [7:0] data_byte;
    logic [7:0] rx_first;
    logic [7:0] rx_block;
    logic [7:0] rx_gap;
    logic [3:0] rx_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [6:0] gap_ms;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/isotp_if.sv @@
// Interfaces: valid/ready channels for input items and result items.
`default_nettype none
interface isotp_in_if;
  logic valid;
  logic ready;
  isotp_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface isotp_out_if;
  logic valid;
  logic ready;
  isotp_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/isotp_front.sv @@
// Front end: protocol state, classification of items and frame assembly.
`default_nettype none
module isotp_front #(
  parameter int MaxPayload = 4090
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  isotp_pkg::in_item_t      item_i,
  output logic                     ready_o,
  output logic                     res_valid_o,
  output isotp_pkg::out_item_t     res_o,
  input  wire logic                q_ready_i
);
  import isotp_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_STREAM = 2'd3;
  localparam logic [11:0] MaxLen = 12'(MaxPayload);

  logic [1:0] phase_q, phase_d;
  logic [7:0] svc_q, svc_d;
  logic [31:0] addr_q, addr_d;
  logic [11:0] total_q, total_d, taken_q, taken_d, taken_inc;
  logic [7:0] buf_q [7];
  logic [7:0] buf_d [7];
  logic [2:0] fill_q, fill_d;
  logic [3:0] seq_q, seq_d;
  logic [7:0] blim_q, blim_d, fib_q, fib_d, fib_inc, sep_q, sep_d;
  logic go;
  logic [11:0] len_sat;
  logic [12:0] ff_total;
  out_item_t r;
  logic rv;

  // one item per cycle while the queue has room
  assign ready_o = q_ready_i;
  assign go = valid_i & q_ready_i;
  assign len_sat = (item_i.length > 16'(MaxLen)) ? MaxLen : item_i.length[11:0];
  assign taken_inc = taken_q + 12'd1;
  assign fib_inc = fib_q + 8'd1;
  assign ff_total = 13'd5 + {1'b0, total_q};

  always_comb begin
    phase_d = phase_q; svc_d = svc_q; addr_d = addr_q; total_d = total_q;
    taken_d = taken_q; buf_d = buf_q; fill_d = fill_q; seq_d = seq_q;
    blim_d = blim_q; fib_d = fib_q; sep_d = sep_q;
    r = '0; rv = 1'b0;
    if (go) begin
      case (item_i.operation)
        OP_START: begin
          if (phase_q != PH_IDLE) begin
            rv = 1'b1; r.kind = KIND_REJECT;
          end else begin
            svc_d = item_i.service; addr_d = item_i.address; total_d = len_sat;
            taken_d = '0; fill_d = '0; seq_d = 4'd1; blim_d = '0; fib_d = '0;
            sep_d = '0;
            if (len_sat == 12'd0) begin
              rv = 1'b1; r.kind = KIND_FRAME; r.last = 1'b1; r.byte0 = 8'd5;
              r.byte1 = item_i.service; r.byte2 = item_i.address[31:24];
              r.byte3 = item_i.address[23:16]; r.byte4 = item_i.address[15:8];
              r.byte5 = item_i.address[7:0];
            end else begin
              phase_d = PH_COLLECT;
            end
          end
        end
        OP_DATA: begin
          if (phase_q == PH_COLLECT && total_q <= 12'd2) begin
            // single frame: at most two data bytes after the header
            if (fill_q < 3'd7) begin
              buf_d[fill_q] = item_i.data_byte; fill_d = fill_q + 3'd1;
            end
            taken_d = taken_inc;
            if (taken_inc >= total_q) begin
              rv = 1'b1; r.kind = KIND_FRAME; r.last = 1'b1;
              r.byte0 = 8'd5 + total_q[7:0];
              r.byte1 = svc_q; r.byte2 = addr_q[31:24]; r.byte3 = addr_q[23:16];
              r.byte4 = addr_q[15:8]; r.byte5 = addr_q[7:0];
              if (total_q >= 12'd1) r.byte6 = (fill_q == 3'd0) ? item_i.data_byte : buf_q[0];
              if (total_q >= 12'd2 && fill_d >= 3'd2)
                r.byte7 = (fill_q == 3'd1) ? item_i.data_byte : buf_q[1];
              phase_d = PH_IDLE;
            end
          end else if (phase_q == PH_COLLECT) begin
            // first frame with one data byte
            rv = 1'b1; r.kind = KIND_FRAME;
            r.byte0 = PCI_FF | {4'd0, ff_total[11:8]};
            r.byte1 = ff_total[7:0];
            r.byte2 = svc_q; r.byte3 = addr_q[31:24]; r.byte4 = addr_q[23:16];
            r.byte5 = addr_q[15:8]; r.byte6 = addr_q[7:0]; r.byte7 = item_i.data_byte;
            taken_d = 12'd1; fill_d = '0; phase_d = PH_WAIT;
          end else if (phase_q == PH_STREAM) begin
            buf_d[fill_q] = item_i.data_byte;
            fill_d = fill_q + 3'd1;
            taken_d = taken_inc;
            if (fill_d == 3'd7 || taken_inc >= total_q) begin
              rv = 1'b1; r.kind = KIND_FRAME;
              r.byte0 = PCI_CF | {4'd0, seq_q};
              r.byte1 = (fill_d > 3'd0) ? buf_d[0] : 8'd0;
              r.byte2 = (fill_d > 3'd1) ? buf_d[1] : 8'd0;
              r.byte3 = (fill_d > 3'd2) ? buf_d[2] : 8'd0;
              r.byte4 = (fill_d > 3'd3) ? buf_d[3] : 8'd0;
              r.byte5 = (fill_d > 3'd4) ? buf_d[4] : 8'd0;
              r.byte6 = (fill_d > 3'd5) ? buf_d[5] : 8'd0;
              r.byte7 = (fill_d > 3'd6) ? buf_d[6] : 8'd0;
              r.gap_ms = (sep_q >= 8'd1 && sep_q <= GAP_MS_MAX) ? sep_q[6:0] : 7'd0;
              fill_d = '0; seq_d = seq_q + 4'd1; fib_d = fib_inc;
              if (taken_inc >= total_q) begin
                r.last = 1'b1; phase_d = PH_IDLE;
              end else if (blim_q != 8'd0 && fib_inc >= blim_q) begin
                fib_d = '0; phase_d = PH_WAIT;
              end
            end
          end else begin
            rv = 1'b1; r.kind = KIND_REJECT;
          end
        end
        OP_RX: begin
          if (phase_q == PH_WAIT && item_i.rx_count >= 4'd3 &&
              (item_i.rx_first & PCI_TYPE_MASK) == PCI_FC) begin
            if (item_i.rx_first[3:0] == 4'd0) begin
              blim_d = item_i.rx_block; sep_d = item_i.rx_gap; fib_d = '0;
              fill_d = '0; phase_d = PH_STREAM;
            end else if (item_i.rx_first[3:0] != 4'd1) begin
              rv = 1'b1; r.kind = KIND_ABORT; r.last = 1'b1; phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          rv = 1'b1; r.kind = KIND_REJECT;
        end
      endcase
    end
  end

  assign res_valid_o = rv;
  assign res_o = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; svc_q <= '0; addr_q <= '0; total_q <= '0; taken_q <= '0;
      fill_q <= '0; seq_q <= 4'd1; blim_q <= '0; fib_q <= '0; sep_q <= '0;
    end else begin
      phase_q <= phase_d; svc_q <= svc_d; addr_q <= addr_d; total_q <= total_d;
      taken_q <= taken_d; fill_q <= fill_d; seq_q <= seq_d; blim_q <= blim_d;
      fib_q <= fib_d; sep_q <= sep_d;
    end
  end

  // frame buffer payload, no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end
endmodule
`default_nettype wire

@@ rtl/core/isotp_queue.sv @@
// Back end: two-entry result queue that decouples front end and output.
`default_nettype none
module isotp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  isotp_pkg::out_item_t data_i,
  output logic                 room_o,
  isotp_out_if.source          out_o
);
  import isotp_pkg::*;

  out_item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic pop;

  assign pop = out_o.valid & out_o.ready;
  assign out_o.valid = cnt_q != 2'd0;
  assign out_o.payload = mem_q[rp_q];
  // room while fewer than two entries are held; a pending pop is not counted
  assign room_o = cnt_q != 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

@@ rtl/core/isotp_segmented_transmitter.sv @@
// Top level: ISO-TP segmented transmitter with flow control.
// Takes one item per cycle (start, data byte or received frame) and produces
// at most one result per item, which is registered in a two-entry queue. The
// input is held off only while that queue is full because the output stalls.
`default_nettype none
module isotp_segmented_transmitter #(
  parameter int MaxPayload = 4090
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  isotp_in_if.sink    in_i,
  isotp_out_if.source out_o
);
  import isotp_pkg::*;

  logic room, rv;
  out_item_t res;

  isotp_front #(.MaxPayload(MaxPayload)) u_front (
    .clk_i, .rst_ni, .valid_i(in_i.valid), .item_i(in_i.payload),
    .ready_o(in_i.ready), .res_valid_o(rv), .res_o(res), .q_ready_i(room)
  );

  isotp_queue u_queue (
    .clk_i, .rst_ni, .push_i(rv), .data_i(res), .room_o(room), .out_o(out_o)
  );
endmodule
`default_nettype wire
